// ----- design/cmm_pkg.sv -----
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared types, codes and helpers of the complex matrix multiplier: payload
// structs of both channels, the command queue entry and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cmm_pkg;

    // Largest matrix dimension and the depth of the command queue
    localparam int CMM_MAX_DIM     = 8;
    localparam int CMM_QUEUE_DEPTH = 4;   // power of two

    // Fixed field widths
    localparam int FUNC_W      = 2;
    localparam int IDX_W       = 6;
    localparam int ELEM_W      = 16;
    localparam int WORD_W      = 2 * ELEM_W;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = 36;
    localparam int DIM_FIELD_W = 4;
    localparam int CFG_IDX_W   = 2;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_LEFT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_RIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_CONTRACT = 2'd2;

    localparam logic [DIM_FIELD_W-1:0] DIM_RESET = 4'd8;

    typedef struct packed {
        logic        [FUNC_W-1:0] func;
        logic        [IDX_W-1:0]  elem_index;
        logic signed [ELEM_W-1:0] elem_re;
        logic signed [ELEM_W-1:0] elem_im;
    } cmm_in_t;

    typedef struct packed {
        logic        [IDX_W-1:0] out_index;
        logic signed [ACC_W-1:0] out_re;
        logic signed [ACC_W-1:0] out_im;
        logic                    last;
    } cmm_out_t;

    typedef enum logic [1:0] {
        KIND_WR_A,
        KIND_WR_B,
        KIND_COMPUTE
    } cmm_kind_t;

    // Queue entry: word holds the real part in the low half
    typedef struct packed {
        cmm_kind_t          kind;
        logic [IDX_W-1:0]   addr;
        logic [WORD_W-1:0]  word;
    } cmm_cmd_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } cmm_seq_t;

    // Force a dimension register into 1..max_dim
    function automatic logic [DIM_FIELD_W-1:0] clamp_dim(
        input logic [DIM_FIELD_W-1:0] d,
        input logic [DIM_FIELD_W-1:0] max_dim
    );
        logic [DIM_FIELD_W-1:0] r;
        if (d == '0)
            r = DIM_FIELD_W'(1);
        else if (d > max_dim)
            r = max_dim;
        else
            r = d;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/cmm_front.sv -----
// ----------------------------------------------------------------------------
// cmm_front
// Accepts items, decodes the function code and pushes loads and compute
// requests into the command queue. Unused codes and loads outside the
// store are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_front
    import cmm_pkg::*;
#(
    parameter int MAX_DIM = CMM_MAX_DIM
)
(
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire cmm_in_t  item,
    input  wire logic     q_full,
    output logic          q_push,
    output cmm_cmd_t      q_cmd
);

    localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W+1)'(MAX_DIM * MAX_DIM);

    logic keep;
    logic in_range;

    assign in_range   = ({1'b0, item.elem_index} < IDX_LIMIT);
    assign item_stall = q_full;

    always_comb
    begin
        keep       = 1'b0;
        q_cmd.kind = KIND_COMPUTE;
        q_cmd.addr = item.elem_index;
        q_cmd.word = {item.elem_im, item.elem_re};
        unique case (item.func)
            FUNC_WR_A:
            begin
                keep       = in_range;
                q_cmd.kind = KIND_WR_A;
            end
            FUNC_WR_B:
            begin
                keep       = in_range;
                q_cmd.kind = KIND_WR_B;
            end
            FUNC_COMPUTE:
            begin
                keep       = 1'b1;
                q_cmd.kind = KIND_COMPUTE;
            end
            default:
            begin
                keep       = 1'b0;
                q_cmd.kind = KIND_COMPUTE;
            end
        endcase
    end

    assign q_push     = item_valid && !q_full && keep;

endmodule

`default_nettype wire

// ----- design/cmm_queue.sv -----
// ----------------------------------------------------------------------------
// cmm_queue
// Short command FIFO between the decoder and the compute engine, so that
// loads keep arriving while a product is being worked out.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_queue
    import cmm_pkg::*;
#(
    parameter int DEPTH = CMM_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire cmm_cmd_t  push_cmd,
    output logic           full,
    input  wire logic      pop,
    output logic           head_valid,
    output cmm_cmd_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmm_cmd_t         entry_reg [DEPTH];
    logic [PTR_W:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W:0]   rd_ptr_reg, rd_ptr_next;

    assign head_valid = (wr_ptr_reg != rd_ptr_reg);
    assign full       = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                        (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
    assign head       = entry_reg[rd_ptr_reg[PTR_W-1:0]];

    assign wr_ptr_next = push ? wr_ptr_reg + (PTR_W+1)'(1) : wr_ptr_reg;
    assign rd_ptr_next = pop  ? rd_ptr_reg + (PTR_W+1)'(1) : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg[PTR_W-1:0]] <= push_cmd;
    end

endmodule

`default_nettype wire

// ----- design/cmm_back.sv -----
// ----------------------------------------------------------------------------
// cmm_back
// Compute engine: holds the dimension registers and both element stores,
// applies loads, runs one complex multiply-accumulate per cycle when not
// stalled, through a read / multiply / accumulate pipeline into result_reg.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_back
    import cmm_pkg::*;
#(
    parameter int MAX_DIM = CMM_MAX_DIM
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_en,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [DIM_FIELD_W-1:0]  cfg_data,
    input  wire logic                    q_valid,
    input  wire cmm_cmd_t                q_head,
    output logic                         q_pop,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output cmm_out_t                     result
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam logic [DIM_FIELD_W-1:0] MAX_DIM_F = DIM_FIELD_W'(MAX_DIM);

    // Configuration
    logic [DIM_FIELD_W-1:0] dim_left_reg, dim_right_reg, dim_contract_reg;
    logic [DIM_W-1:0]       nl, nr, nc;
    logic [CNT_W-1:0]       nl_m1, nr_m1, nc_m1;

    // Sequencer
    cmm_seq_t               state_reg, state_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic [CNT_W-1:0]       row_reg, row_next;
    logic [CNT_W-1:0]       col_reg, col_next;
    logic [ADDR_W-1:0]      a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0]      b_addr_reg, b_addr_next;
    logic [ADDR_W-1:0]      col_base_reg, col_base_next;
    logic [ADDR_W-1:0]      m_reg, m_next;
    logic                   en;
    logic                   start;
    logic                   issue;
    logic                   wr_a;
    logic                   wr_b;
    logic                   k_end, row_end, col_end;

    // Stores
    logic [WORD_W-1:0]      mem_a [DEPTH];
    logic [WORD_W-1:0]      mem_b [DEPTH];

    // Stage 1: store read
    logic                   s1_valid_reg, s1_first_reg, s1_lastk_reg, s1_final_reg;
    logic [ADDR_W-1:0]      s1_index_reg;
    logic [WORD_W-1:0]      a_rd_reg, b_rd_reg;

    // Stage 2: products
    logic                   s2_valid_reg, s2_first_reg, s2_lastk_reg, s2_final_reg;
    logic [ADDR_W-1:0]      s2_index_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [ELEM_W-1:0] ar, ai, br, bi;

    // Stage 3: accumulate
    logic signed [PROD_W:0]   term_re, term_im;
    logic signed [ACC_W-1:0]  base_re, base_im, sum_re, sum_im;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic                     result_valid_reg;
    cmm_out_t                 result_reg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_left_reg     <= DIM_RESET;
            dim_right_reg    <= DIM_RESET;
            dim_contract_reg <= DIM_RESET;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                CFG_DIM_LEFT:     dim_left_reg     <= cfg_data;
                CFG_DIM_RIGHT:    dim_right_reg    <= cfg_data;
                CFG_DIM_CONTRACT: dim_contract_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign nl    = DIM_W'(clamp_dim(dim_left_reg, MAX_DIM_F));
    assign nr    = DIM_W'(clamp_dim(dim_right_reg, MAX_DIM_F));
    assign nc    = DIM_W'(clamp_dim(dim_contract_reg, MAX_DIM_F));
    assign nl_m1 = CNT_W'(nl - DIM_W'(1));
    assign nr_m1 = CNT_W'(nr - DIM_W'(1));
    assign nc_m1 = CNT_W'(nc - DIM_W'(1));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    // Freeze the whole engine while a finished result is held off
    assign en      = !result_valid_reg || !result_stall;
    assign k_end   = (k_reg == nc_m1);
    assign row_end = (row_reg == nl_m1);
    assign col_end = (col_reg == nr_m1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                    state_next = SEQ_RUN;
            end
            SEQ_RUN:
            begin
                if (issue && k_end && row_end && col_end)
                    state_next = SEQ_IDLE;
            end
            default:
                state_next = SEQ_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        issue = 1'b0;
        start = 1'b0;
        wr_a  = 1'b0;
        wr_b  = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                q_pop = en && q_valid;
                start = q_pop && (q_head.kind == KIND_COMPUTE);
                wr_a  = q_pop && (q_head.kind == KIND_WR_A);
                wr_b  = q_pop && (q_head.kind == KIND_WR_B);
            end
            SEQ_RUN:
                issue = en;
            default:
                issue = 1'b0;
        endcase
    end

    // Walk k fastest, then row, then column; addresses advance by adds
    always_comb
    begin
        k_next        = k_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        a_addr_next   = a_addr_reg;
        b_addr_next   = b_addr_reg;
        col_base_next = col_base_reg;
        m_next        = m_reg;
        if (start)
        begin
            k_next        = '0;
            row_next      = '0;
            col_next      = '0;
            a_addr_next   = '0;
            b_addr_next   = '0;
            col_base_next = '0;
            m_next        = '0;
        end
        else if (issue)
        begin
            if (!k_end)
            begin
                k_next      = k_reg + CNT_W'(1);
                a_addr_next = a_addr_reg + ADDR_W'(nl);
                b_addr_next = b_addr_reg + ADDR_W'(1);
            end
            else
            begin
                k_next = '0;
                m_next = m_reg + ADDR_W'(1);
                if (!row_end)
                begin
                    row_next    = row_reg + CNT_W'(1);
                    a_addr_next = ADDR_W'(row_reg) + ADDR_W'(1);
                    b_addr_next = col_base_reg;
                end
                else
                begin
                    row_next      = '0;
                    col_next      = col_reg + CNT_W'(1);
                    a_addr_next   = '0;
                    col_base_next = col_base_reg + ADDR_W'(nc);
                    b_addr_next   = col_base_reg + ADDR_W'(nc);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SEQ_IDLE;
            k_reg        <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            a_addr_reg   <= '0;
            b_addr_reg   <= '0;
            col_base_reg <= '0;
            m_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            a_addr_reg   <= a_addr_next;
            b_addr_reg   <= b_addr_next;
            col_base_reg <= col_base_next;
            m_reg        <= m_next;
        end
    end

    // ------------------------------------------------------------------
    // Element stores with registered read
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_a)
            mem_a[q_head.addr[ADDR_W-1:0]] <= q_head.word;
        if (issue)
            a_rd_reg <= mem_a[a_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
            mem_b[q_head.addr[ADDR_W-1:0]] <= q_head.word;
        if (issue)
            b_rd_reg <= mem_b[b_addr_reg];
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg     <= issue;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg && s2_lastk_reg;
        end
    end

    // ------------------------------------------------------------------
    // Tags and products
    // ------------------------------------------------------------------
    assign ar = a_rd_reg[ELEM_W-1:0];
    assign ai = a_rd_reg[WORD_W-1:ELEM_W];
    assign br = b_rd_reg[ELEM_W-1:0];
    assign bi = b_rd_reg[WORD_W-1:ELEM_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_first_reg <= (k_reg == '0);
            s1_lastk_reg <= k_end;
            s1_final_reg <= k_end && row_end && col_end;
            s1_index_reg <= m_reg;

            s2_first_reg <= s1_first_reg;
            s2_lastk_reg <= s1_lastk_reg;
            s2_final_reg <= s1_final_reg;
            s2_index_reg <= s1_index_reg;
            p_rr_reg     <= ar * br;
            p_ii_reg     <= ai * bi;
            p_ri_reg     <= ar * bi;
            p_ir_reg     <= ai * br;
        end
    end

    // ------------------------------------------------------------------
    // Accumulate and result register
    // ------------------------------------------------------------------
    assign term_re = {p_rr_reg[PROD_W-1], p_rr_reg} - {p_ii_reg[PROD_W-1], p_ii_reg};
    assign term_im = {p_ri_reg[PROD_W-1], p_ri_reg} + {p_ir_reg[PROD_W-1], p_ir_reg};
    assign base_re = s2_first_reg ? '0 : acc_re_reg;
    assign base_im = s2_first_reg ? '0 : acc_im_reg;
    assign sum_re  = base_re + {{(ACC_W-PROD_W-1){term_re[PROD_W]}}, term_re};
    assign sum_im  = base_im + {{(ACC_W-PROD_W-1){term_im[PROD_W]}}, term_im};

    always_ff @(posedge clk)
    begin
        if (en && s2_valid_reg)
        begin
            acc_re_reg <= sum_re;
            acc_im_reg <= sum_im;
            if (s2_lastk_reg)
            begin
                result_reg.out_index <= IDX_W'(s2_index_reg);
                result_reg.out_re    <= sum_re;
                result_reg.out_im    <= sum_im;
                result_reg.last      <= s2_final_reg;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SEQ_RUN |-> (k_reg <= nc_m1) && (row_reg <= nl_m1) &&
                                 (col_reg <= nr_m1))
        else $error("sequencer counter beyond dimension");

    a_addr_a_track: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SEQ_RUN |->
            int'(a_addr_reg) == int'(row_reg) + int'(k_reg) * int'(nl))
        else $error("A address out of step with row and k");

    a_addr_b_track: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SEQ_RUN |->
            int'(b_addr_reg) == int'(k_reg) + int'(col_reg) * int'(nc))
        else $error("B address out of step with k and column");

    a_index_track: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SEQ_RUN |->
            int'(m_reg) == int'(row_reg) + int'(col_reg) * int'(nl))
        else $error("result index out of step with row and column");

    a_final_on_lastk: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_final_reg |-> s2_lastk_reg)
        else $error("final flag on a partial sum");

endmodule

`default_nettype wire

// ----- design/complex_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// complex_matrix_multiply
// Complex matrix product C = A*B, column-major, Q1.15 inputs, exact results
// with 30 fractional bits.
//
// Loads: one item per cycle while the queue is not full, written into its
// store when the idle engine pops it; loads behind a compute wait in the
// 4-entry queue. Compute: after the pop, dim_left*dim_right*dim_contract
// complex multiply-adds issue, one per cycle while no result is held off,
// through the store read, product and accumulate registers. A stalled
// result freezes the engine. Reset clears control and sets all dimensions
// to 8; stores stay undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_matrix_multiply
    import cmm_pkg::*;
#(
    parameter int MAX_DIM = CMM_MAX_DIM
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    item_valid,
    output logic                         item_stall,
    input  wire cmm_in_t                 item,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output cmm_out_t                     result,
    input  wire logic                    cfg_en,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [DIM_FIELD_W-1:0]  cfg_data
);

    logic     q_full;
    logic     q_push;
    cmm_cmd_t q_cmd;
    logic     q_pop;
    logic     q_valid;
    cmm_cmd_t q_head;

    cmm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    cmm_queue #(
        .DEPTH (CMM_QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    cmm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_en       (cfg_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
